### sv/npcm_pkg.sv
package npcm_pkg;

    localparam int CHAN_W = 8;
    localparam int SLOT_W = 4;
    localparam int SIZE_W = 5;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int DIST_W = SQ_W + 2;

    // Item operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [SLOT_W-1:0] chosen_slot;
        logic              no_palette;
    } out_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] score;
        color_t            color;
    } best_t;

    function automatic logic [SQ_W-1:0] gap_sq(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            gap_sq = SQ_W'(d) * SQ_W'(d);
        end
    endfunction

    function automatic logic [DIST_W-1:0] color_dist2(input color_t c,
                                                      input in_item_t px);
        begin
            color_dist2 = DIST_W'(gap_sq(c.red, px.pixel_red))
                        + DIST_W'(gap_sq(c.green, px.pixel_green))
                        + DIST_W'(gap_sq(c.blue, px.pixel_blue));
        end
    endfunction

endpackage

### sv/npcm_cell.sv
module npcm_cell
    import npcm_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [SIZE_W-1:0] palette_size,
    input  logic              up_valid,
    input  in_item_t          up_item,
    input  best_t             up_best,
    input  logic [IDX_W-1:0]  up_slot,
    output logic              dn_valid,
    output in_item_t          dn_item,
    output best_t             dn_best,
    output logic [IDX_W-1:0]  dn_slot
);

    localparam int SLOT_RANGE = 1 << SLOT_W;

    color_t            color_reg;
    logic              valid_reg;
    in_item_t          item_reg;
    best_t             best_reg;
    logic [IDX_W-1:0]  slot_reg;

    logic              load_hit;
    logic              active;
    logic [DIST_W-1:0] score;
    logic              take;
    best_t             best_next;
    logic [IDX_W-1:0]  slot_next;

    // Match a load transaction against this cell's slot
    assign load_hit = up_valid && (up_item.op == OP_LOAD) && (CELL_INDEX < SLOT_RANGE)
                   && (up_item.slot == SLOT_W'(CELL_INDEX));

    // Search this slot only while it lies inside the palette
    assign active = int'(palette_size) > CELL_INDEX;
    assign score  = color_dist2(color_reg, up_item);
    assign take   = up_valid && (up_item.op == OP_MAP) && active
                 && (!up_best.found || (score < up_best.score));

    always_comb
    begin
        best_next = up_best;
        slot_next = up_slot;
        if (take)
        begin
            best_next.found = 1'b1;
            best_next.score = score;
            best_next.color = color_reg;
            slot_next       = IDX_W'(CELL_INDEX);
        end
    end

    // Store the palette entry
    always_ff @(posedge clk)
    begin
        if (advance && load_hit)
        begin
            color_reg.red   <= up_item.pixel_red;
            color_reg.green <= up_item.pixel_green;
            color_reg.blue  <= up_item.pixel_blue;
        end
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= up_valid;
        end
    end

    // Hand the transaction and running result to the next cell
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= up_item;
            best_reg <= best_next;
            slot_reg <= slot_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;
    assign dn_best  = best_reg;
    assign dn_slot  = slot_reg;

endmodule

### sv/nearest_palette_color_mapper.sv
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_item  (op, slot, pixel_red/green/blue)
// out       out_valid / out_stall  out_item (out_red/green/blue, chosen_slot, no_palette)
// cfg       cfg_we                 cfg_wdata (palette_size)
//
// One transaction enters per cycle while in_stall is low; a map result passes through
// the chain of cells, one per palette slot, each holding one stored color.
// Load transactions travel the same chain and write their cell in passing.
// Reset clears the stage valid bits and palette_size; palette contents stay unknown.
// A result held under out_stall freezes the whole chain and raises in_stall.
module nearest_palette_color_mapper
    import npcm_pkg::*;
#(
    parameter int PALETTE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [SIZE_W-1:0]  palette_size_reg;
    logic               advance;

    logic               stage_valid [PALETTE_DEPTH+1];
    in_item_t           stage_item  [PALETTE_DEPTH+1];
    best_t              stage_best  [PALETTE_DEPTH+1];
    logic [IDX_W-1:0]   stage_slot  [PALETTE_DEPTH+1];

    logic [IDX_W+SLOT_W-1:0] slot_wide;

    // Hold the palette size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            palette_size_reg <= cfg_wdata;
        end
    end

    // Freeze the chain while a result waits
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // Feed the head of the chain with an empty search result
    assign stage_valid[0] = in_valid;
    assign stage_item[0]  = in_item;
    assign stage_best[0]  = '0;
    assign stage_slot[0]  = '0;

    for (genvar k = 0; k < PALETTE_DEPTH; k++)
    begin : g_cell
        npcm_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .palette_size (palette_size_reg),
            .up_valid     (stage_valid[k]),
            .up_item      (stage_item[k]),
            .up_best      (stage_best[k]),
            .up_slot      (stage_slot[k]),
            .dn_valid     (stage_valid[k+1]),
            .dn_item      (stage_item[k+1]),
            .dn_best      (stage_best[k+1]),
            .dn_slot      (stage_slot[k+1])
        );
    end

    // Present map results at the tail; drop loads
    assign out_valid = stage_valid[PALETTE_DEPTH]
                    && (stage_item[PALETTE_DEPTH].op == OP_MAP);
    assign slot_wide = {{SLOT_W{1'b0}}, stage_slot[PALETTE_DEPTH]};

    always_comb
    begin
        if (stage_best[PALETTE_DEPTH].found)
        begin
            out_item.out_red     = stage_best[PALETTE_DEPTH].color.red;
            out_item.out_green   = stage_best[PALETTE_DEPTH].color.green;
            out_item.out_blue    = stage_best[PALETTE_DEPTH].color.blue;
            out_item.chosen_slot = slot_wide[SLOT_W-1:0];
            out_item.no_palette  = 1'b0;
        end
        else
        begin
            out_item = '0;
            out_item.no_palette = 1'b1;
        end
    end

endmodule

### sv/npcm_checker.sv
module npcm_checker
    import npcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    // Stall the input only behind a stalled result
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // Keep taking transactions while the output side is free
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output idle");

    // Drive black and slot zero for an empty palette
    a_empty_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.no_palette |->
            out_item.out_red == '0 && out_item.out_green == '0 &&
            out_item.out_blue == '0 && out_item.chosen_slot == '0)
        else $error("empty palette result not black");

endmodule

bind nearest_palette_color_mapper npcm_checker u_npcm_checker (.*);
